[rtl/core/assert_macros.svh]
// assertion macros shared by the langevin force update rtl
// no dependencies; included by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define AST_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/lgv_pkg.sv]
// types, constants and register codes of the langevin force update
// no dependencies; imported by every module of the block
package lgv_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int RAND_BITS   = 16;
    localparam int ID_W        = 32;
    localparam int MASS_W      = 32;
    localparam int DIV_W       = 16;
    localparam int GAIN_W      = 32;
    localparam int SQ_W        = (MASS_W + FRAC_BITS) / 2;
    localparam int SQ_REM_W    = SQ_W + 3;
    localparam int FR_STAGES   = 8;
    localparam int DIV_STEPS   = ID_W / FR_STAGES;
    localparam int SQ_STEPS    = SQ_W / FR_STAGES;
    localparam int Q1_W        = GAIN_W + RAND_BITS;
    localparam int F2_W        = Q1_W + SQ_W;
    localparam int TERM_W      = 41;
    localparam int SUM_W       = 43;
    localparam logic [31:0] SQRT3_Q30 = 32'd1859775393;

    // register indexes
    localparam logic [2:0] REG_FRICTION_ONE = 3'd0;
    localparam logic [2:0] REG_NOISE_ONE    = 3'd1;
    localparam logic [2:0] REG_FRICTION_TWO = 3'd2;
    localparam logic [2:0] REG_NOISE_TWO    = 3'd3;
    localparam logic [2:0] REG_FIRST_PAR    = 3'd4;
    localparam logic [2:0] REG_SECOND_PAR   = 3'd5;
    localparam logic [2:0] REG_MOL_CHAIN    = 3'd6;
    localparam logic [2:0] REG_HEAT_BOOST   = 3'd7;

    // group codes
    localparam logic [1:0] GRP_NONE = 2'd0;
    localparam logic [1:0] GRP_ONE  = 2'd1;
    localparam logic [1:0] GRP_TWO  = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   particle_id;
        logic [MASS_W-1:0] mass;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] force_in_x;
        logic signed [31:0] force_in_y;
        logic signed [31:0] force_in_z;
        logic [15:0] rand_x;
        logic [15:0] rand_y;
        logic [15:0] rand_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] force_out_x;
        logic signed [31:0] force_out_y;
        logic signed [31:0] force_out_z;
        logic [1:0] group_used;
        logic saturated;
    } out_t;

    // settings seen by the arithmetic, noise gains already boosted
    typedef struct packed {
        logic [GAIN_W-1:0] friction_one;
        logic [GAIN_W-1:0] noise_one;
        logic [GAIN_W-1:0] friction_two;
        logic [GAIN_W-1:0] noise_two;
        logic first_parity;
        logic second_parity;
        logic [DIV_W-1:0] divisor;
    } cfg_t;

    // front stage: divider and square root partials
    typedef struct packed {
        in_t item;
        logic [DIV_W-1:0] drem;
        logic qbit;
        logic [SQ_REM_W-1:0] srem;
        logic [SQ_W-1:0] root;
    } fr_t;

    typedef struct packed {
        logic [63:0] p1;
        logic fneg;
        logic [Q1_W-1:0] q1;
        logic cneg;
        logic [31:0] frc;
    } lane_a_t;

    typedef struct packed {
        logic [63:0] p_lo;
        logic [63:0] p_hi;
        logic [2*SQ_W-1:0] q_lo;
        logic [Q1_W-1:0] q_hi;
        logic fneg;
        logic cneg;
        logic [31:0] frc;
    } lane_b_t;

    typedef struct packed {
        logic [TERM_W-1:0] t1;
        logic [TERM_W-1:0] t2;
        logic fneg;
        logic cneg;
        logic [31:0] frc;
    } lane_c_t;

endpackage

[rtl/core/lgv_front.sv]
// front pipeline: chain parity by restoring division and sqrt of mass
// depends on lgv_pkg and assert_macros.svh
`include "assert_macros.svh"
module lgv_front import lgv_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [DIV_W-1:0] divisor,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_t              s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output fr_t              m_data
);

    logic [FR_STAGES-1:0] valid_reg;
    logic [FR_STAGES-1:0] ready;
    logic [FR_STAGES-1:0] src_valid;
    fr_t stage_reg [FR_STAGES];
    fr_t stage_next [FR_STAGES];
    fr_t src [FR_STAGES];

    genvar k;
    generate
        for (k = 0; k < FR_STAGES; k++) begin : g_stage
            logic [2*SQ_W-1:0] x;
            logic [DIV_W:0] t;
            logic [SQ_REM_W-1:0] sh;
            logic [SQ_REM_W-1:0] trial;
            fr_t w;

            // stage input and ready chain
            if (k == 0) begin : g_first
                assign src[k] = '{item: s_data, drem: '0, qbit: 1'b0, srem: '0, root: '0};
                assign src_valid[k] = s_valid;
            end else begin : g_mid
                assign src[k] = stage_reg[k-1];
                assign src_valid[k] = valid_reg[k-1];
            end
            if (k == FR_STAGES - 1) begin : g_last
                assign ready[k] = !valid_reg[k] || m_ready;
            end else begin : g_inner
                assign ready[k] = !valid_reg[k] || ready[k+1];
            end

            // a few division and square root digits per stage
            always_comb begin
                w = src[k];
                x = {w.item.mass, {FRAC_BITS{1'b0}}};
                for (int j = 0; j < DIV_STEPS; j++) begin
                    t = {w.drem, w.item.particle_id[ID_W-1-(k*DIV_STEPS+j)]};
                    if (t >= {1'b0, divisor}) begin
                        t = t - {1'b0, divisor};
                        w.qbit = 1'b1;
                    end else begin
                        w.qbit = 1'b0;
                    end
                    w.drem = t[DIV_W-1:0];
                end
                for (int j = 0; j < SQ_STEPS; j++) begin
                    sh = {w.srem[SQ_REM_W-3:0], x[2*(SQ_W-1-(k*SQ_STEPS+j)) +: 2]};
                    trial = {1'b0, w.root, 2'b01};
                    if (sh >= trial) begin
                        w.srem = sh - trial;
                        w.root = {w.root[SQ_W-2:0], 1'b1};
                    end else begin
                        w.srem = sh;
                        w.root = {w.root[SQ_W-2:0], 1'b0};
                    end
                end
                stage_next[k] = w;
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k] <= 1'b0;
                end else if (ready[k]) begin
                    valid_reg[k] <= src_valid[k];
                end
                if (ready[k] && src_valid[k]) begin
                    stage_reg[k] <= stage_next[k];
                end
            end
        end
    endgenerate

    assign s_ready = ready[0];
    assign m_valid = valid_reg[FR_STAGES-1];
    assign m_data  = stage_reg[FR_STAGES-1];

    // checks
    `AST_NEXT(a_enter, aclk, aresetn, s_valid && s_ready, valid_reg[0])
    `AST_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready,
              m_valid && $stable(m_data))

endmodule

[rtl/core/lgv_mult.sv]
// back pipeline: group select, friction and noise products, saturating sum
// depends on lgv_pkg and assert_macros.svh
`include "assert_macros.svh"
module lgv_mult import lgv_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  logic s_valid,
    output logic s_ready,
    input  fr_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam logic [TERM_W-1:0] CLIP = TERM_W'(1) << (TERM_W - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sd2147483648);

    logic [3:0] valid_reg;
    logic [3:0] ready;

    lane_a_t a_next [3];
    lane_a_t a_reg  [3];
    lane_b_t b_next [3];
    lane_b_t b_reg  [3];
    lane_c_t c_next [3];
    lane_c_t c_reg  [3];
    logic [31:0] res_next [3];
    logic [2:0] sat_lane;

    logic [1:0] grp;
    logic [GAIN_W-1:0] gf;
    logic [GAIN_W-1:0] gn;
    logic [GAIN_W-1:0] gmag;
    logic [1:0] grp_a_reg, grp_b_reg, grp_c_reg;
    logic [MASS_W-1:0] mass_a_reg;
    logic [SQ_W-1:0] sq_a_reg, sq_b_reg;
    out_t out_reg;

    logic signed [31:0] vel [3];
    logic signed [31:0] frc [3];
    logic [15:0] rnd [3];

    assign vel = '{s_data.item.vel_x, s_data.item.vel_y, s_data.item.vel_z};
    assign frc = '{s_data.item.force_in_x, s_data.item.force_in_y, s_data.item.force_in_z};
    assign rnd = '{s_data.item.rand_x, s_data.item.rand_y, s_data.item.rand_z};

    // ready chain, last stage is the output register
    assign ready[3] = !valid_reg[3] || m_ready;
    assign ready[2] = !valid_reg[2] || ready[3];
    assign ready[1] = !valid_reg[1] || ready[2];
    assign ready[0] = !valid_reg[0] || ready[1];
    assign s_ready  = ready[0];

    // group select from chain parity
    always_comb begin
        if (s_data.qbit == cfg.first_parity) begin
            grp = GRP_ONE;
        end else if (s_data.qbit == cfg.second_parity) begin
            grp = GRP_TWO;
        end else begin
            grp = GRP_NONE;
        end
        gf = (grp == GRP_TWO) ? cfg.friction_two : cfg.friction_one;
        gn = (grp == GRP_TWO) ? cfg.noise_two : cfg.noise_one;
        gmag = gf[GAIN_W-1] ? (GAIN_W'(0) - gf) : gf;
    end

    genvar l;
    generate
        for (l = 0; l < 3; l++) begin : g_lane
            logic [31:0] vmag;
            logic [RAND_BITS-1:0] r;
            logic [RAND_BITS-1:0] cmag;
            logic [95:0] full1;
            logic [95:0] t1r;
            logic [F2_W-1:0] full2;
            logic [F2_W-1:0] t2r;
            logic signed [SUM_W-1:0] sum;
            logic signed [SUM_W-1:0] s1;
            logic signed [SUM_W-1:0] s2;

            // stage a: gain times velocity, gain times centered draw
            always_comb begin
                vmag = vel[l][31] ? (32'd0 - vel[l]) : vel[l];
                r = rnd[l][RAND_BITS-1:0];
                cmag = r[RAND_BITS-1] ? {1'b0, r[RAND_BITS-2:0]}
                                      : ({1'b1, {(RAND_BITS-1){1'b0}}} - r);
                a_next[l].p1   = 64'(gmag) * 64'(vmag);
                a_next[l].fneg = gf[GAIN_W-1] ^ vel[l][31];
                a_next[l].q1   = Q1_W'(gn) * Q1_W'(cmag);
                a_next[l].cneg = !r[RAND_BITS-1];
                a_next[l].frc  = frc[l];
            end

            // stage b: partial products with mass and sqrt of mass
            always_comb begin
                b_next[l].p_lo = 64'(a_reg[l].p1[31:0]) * 64'(mass_a_reg);
                b_next[l].p_hi = 64'(a_reg[l].p1[63:32]) * 64'(mass_a_reg);
                b_next[l].q_lo = (2*SQ_W)'(a_reg[l].q1[SQ_W-1:0]) * (2*SQ_W)'(sq_a_reg);
                b_next[l].q_hi = Q1_W'(a_reg[l].q1[Q1_W-1:SQ_W]) * Q1_W'(sq_a_reg);
                b_next[l].fneg = a_reg[l].fneg;
                b_next[l].cneg = a_reg[l].cneg;
                b_next[l].frc  = a_reg[l].frc;
            end

            // stage c: combine, drop fraction bits, clip magnitudes
            always_comb begin
                full1 = {b_reg[l].p_hi, 32'd0} + {32'd0, b_reg[l].p_lo};
                t1r = full1 >> (2 * FRAC_BITS);
                full2 = {b_reg[l].q_hi, {SQ_W{1'b0}}} + F2_W'(b_reg[l].q_lo);
                t2r = full2 >> (FRAC_BITS + RAND_BITS);
                c_next[l].t1 = (t1r > 96'(CLIP)) ? CLIP : t1r[TERM_W-1:0];
                c_next[l].t2 = (t2r > F2_W'(CLIP)) ? CLIP : t2r[TERM_W-1:0];
                c_next[l].fneg = b_reg[l].fneg;
                c_next[l].cneg = b_reg[l].cneg;
                c_next[l].frc  = b_reg[l].frc;
            end

            // stage d: signed sum and saturation; with no group the force passes unchanged
            always_comb begin
                s1 = $signed({2'b00, c_reg[l].t1});
                s2 = $signed({2'b00, c_reg[l].t2});
                sum = $signed({{(SUM_W-32){c_reg[l].frc[31]}}, c_reg[l].frc})
                    + (c_reg[l].fneg ? -s1 : s1) + (c_reg[l].cneg ? -s2 : s2);
                if (grp_c_reg == GRP_NONE) begin
                    res_next[l] = c_reg[l].frc;
                    sat_lane[l] = 1'b0;
                end else if (sum > SAT_HI) begin
                    res_next[l] = 32'h7FFF_FFFF;
                    sat_lane[l] = 1'b1;
                end else if (sum < SAT_LO) begin
                    res_next[l] = 32'h8000_0000;
                    sat_lane[l] = 1'b1;
                end else begin
                    res_next[l] = sum[31:0];
                    sat_lane[l] = 1'b0;
                end
            end
        end
    endgenerate

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (ready[0]) valid_reg[0] <= s_valid;
            if (ready[1]) valid_reg[1] <= valid_reg[0];
            if (ready[2]) valid_reg[2] <= valid_reg[1];
            if (ready[3]) valid_reg[3] <= valid_reg[2];
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (ready[0] && s_valid) begin
            a_reg <= a_next;
            grp_a_reg <= grp;
            mass_a_reg <= s_data.item.mass;
            sq_a_reg <= s_data.root;
        end
        if (ready[1] && valid_reg[0]) begin
            b_reg <= b_next;
            grp_b_reg <= grp_a_reg;
            sq_b_reg <= sq_a_reg;
        end
        if (ready[2] && valid_reg[1]) begin
            c_reg <= c_next;
            grp_c_reg <= grp_b_reg;
        end
        if (ready[3] && valid_reg[2]) begin
            out_reg.force_out_x <= res_next[0];
            out_reg.force_out_y <= res_next[1];
            out_reg.force_out_z <= res_next[2];
            out_reg.group_used  <= grp_c_reg;
            out_reg.saturated   <= |sat_lane;
        end
    end

    assign m_valid = valid_reg[3];
    assign m_data  = out_reg;

    // checks
    `AST_IMPL(a_sat_grp, aclk, aresetn, m_valid && m_data.saturated,
              m_data.group_used != GRP_NONE)
    `AST_NEXT(a_sq_follow, aclk, aresetn, ready[1] && valid_reg[0],
              sq_b_reg == $past(sq_a_reg))

endmodule

[rtl/core/two_group_langevin_force_update.sv]
// top level of the two-group langevin force update with its registers
// depends on lgv_pkg, lgv_front and lgv_mult
//
//  channel  | ports                         | direction
//  ---------+-------------------------------+----------
//  request  | s_valid s_ready s_data        | in
//  result   | m_valid m_ready m_data        | out
//  config   | cfg_we cfg_index cfg_data     | in
//
// one request per cycle while m_ready keeps the pipe moving; a request passes 8
// stages of restoring division and sqrt digits, then 4 multiply, combine and sum
// stages. each stage advances when its successor is free, so bubbles close up
// and a stall at m_ready backs up stage by stage without loss or repeat.
// synchronous active-low reset clears the stage valids and sets the config registers to their defaults.
module two_group_langevin_force_update import lgv_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data
);

    logic [GAIN_W-1:0] friction_one_reg, friction_two_reg;
    logic [GAIN_W-2:0] noise_one_reg, noise_two_reg;
    logic first_par_reg, second_par_reg, heat_reg;
    logic [DIV_W-1:0] mol_chain_reg;
    logic [GAIN_W-1:0] eff_one_reg, eff_two_reg;
    logic [63:0] boost_one, boost_two;
    cfg_t cfg;
    logic fr_valid, fr_ready;
    fr_t fr_data;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            friction_one_reg <= '0;
            noise_one_reg    <= '0;
            friction_two_reg <= '0;
            noise_two_reg    <= '0;
            first_par_reg    <= 1'b0;
            second_par_reg   <= 1'b1;
            mol_chain_reg    <= DIV_W'(1);
            heat_reg         <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FRICTION_ONE: friction_one_reg <= cfg_data;
                REG_NOISE_ONE:    noise_one_reg    <= cfg_data[GAIN_W-2:0];
                REG_FRICTION_TWO: friction_two_reg <= cfg_data;
                REG_NOISE_TWO:    noise_two_reg    <= cfg_data[GAIN_W-2:0];
                REG_FIRST_PAR:    first_par_reg    <= cfg_data[0];
                REG_SECOND_PAR:   second_par_reg   <= cfg_data[0];
                REG_MOL_CHAIN:    mol_chain_reg    <= cfg_data[DIV_W-1:0];
                REG_HEAT_BOOST:   heat_reg         <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // noise gains scaled by sqrt(3) when boosted
    assign boost_one = 64'(noise_one_reg) * 64'(SQRT3_Q30);
    assign boost_two = 64'(noise_two_reg) * 64'(SQRT3_Q30);

    always_ff @(posedge aclk) begin
        eff_one_reg <= heat_reg ? boost_one[61:30] : {1'b0, noise_one_reg};
        eff_two_reg <= heat_reg ? boost_two[61:30] : {1'b0, noise_two_reg};
    end

    always_comb begin
        cfg.friction_one  = friction_one_reg;
        cfg.noise_one     = eff_one_reg;
        cfg.friction_two  = friction_two_reg;
        cfg.noise_two     = eff_two_reg;
        cfg.first_parity  = first_par_reg;
        cfg.second_parity = second_par_reg;
        cfg.divisor       = (mol_chain_reg == '0) ? DIV_W'(1) : mol_chain_reg;
    end

    lgv_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .divisor (cfg.divisor),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (fr_valid),
        .m_ready (fr_ready),
        .m_data  (fr_data)
    );

    lgv_mult u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (fr_valid),
        .s_ready (fr_ready),
        .s_data  (fr_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
